>>> hw/rtl/gpio_pkg.sv
// ----------------------------------------------------------------------------
// gpio_pkg
// Shared types, command codes and register indexes of the GPIO register block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpio_pkg;

    // Width of every data word on the bus and on the pin side.
    localparam int WORD_W = 32;

    // Default number of implemented pins.
    localparam int PIN_COUNT_DEF = 32;

    // Request and result stream widths, padded to whole bytes.
    localparam int IN_BITS    = 2 + 4 + 3 * WORD_W;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 3 * WORD_W + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Request commands.
    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_SAMPLE = 2'd2;

    // Register map.
    localparam logic [3:0] REG_DIR       = 4'd0;
    localparam logic [3:0] REG_INTR_EN   = 4'd1;
    localparam logic [3:0] REG_PULL_EN   = 4'd2;
    localparam logic [3:0] REG_PULL_UP   = 4'd3;
    localparam logic [3:0] REG_DATA_IN   = 4'd4;
    localparam logic [3:0] REG_DATA_OUT  = 4'd5;
    localparam logic [3:0] REG_SET       = 4'd6;
    localparam logic [3:0] REG_CLEAR     = 4'd7;
    localparam logic [3:0] REG_INVERT    = 4'd8;
    localparam logic [3:0] REG_CHANGE    = 4'd9;
    localparam logic [3:0] REG_ACK       = 4'd10;
    localparam logic [3:0] REG_RISE_EN   = 4'd11;
    localparam logic [3:0] REG_FALL_EN   = 4'd12;

    // One request as held in the input register.
    typedef struct packed {
        logic [WORD_W-1:0] pin_hiz;
        logic [WORD_W-1:0] pin_level;
        logic [WORD_W-1:0] wdata;
        logic [3:0]        reg_index;
        logic [1:0]        cmd;
    } item_t;

    // One result as held in the output register.
    typedef struct packed {
        logic              irq;
        logic [WORD_W-1:0] pin_oe;
        logic [WORD_W-1:0] pin_out;
        logic [WORD_W-1:0] rdata;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/gpio_in_reg.sv
// ----------------------------------------------------------------------------
// gpio_in_reg
// Input register stage: holds one request until the register file takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_in_reg
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire gpio_pkg::item_t in_item,
    output logic                 item_valid,
    input  wire logic            item_take,
    output gpio_pkg::item_t      item
);
    import gpio_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The stage is free when empty or when its request leaves this cycle.
    assign in_ready   = !valid_reg || item_take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !item_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Request payload, loaded on every accepted request.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gpio_regfile.sv
// ----------------------------------------------------------------------------
// gpio_regfile
// Pin mask registers with bus read/write decode and edge detection on samples.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_regfile
#(
    parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEF
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire gpio_pkg::item_t item,
    output gpio_pkg::result_t    result
);
    import gpio_pkg::*;

    // Implemented pins; bits above these always read as zero.
    localparam int PW = (PIN_COUNT < WORD_W) ? PIN_COUNT : WORD_W;

    logic [PW-1:0] dir_reg, dir_next;
    logic [PW-1:0] ie_reg, ie_next;
    logic [PW-1:0] pe_reg, pe_next;
    logic [PW-1:0] pu_reg, pu_next;
    logic [PW-1:0] dout_reg, dout_next;
    logic [PW-1:0] set_reg, set_next;
    logic [PW-1:0] clr_reg, clr_next;
    logic [PW-1:0] inv_reg, inv_next;
    logic [PW-1:0] chg_reg, chg_next;
    logic [PW-1:0] ack_reg, ack_next;
    logic [PW-1:0] rise_reg, rise_next;
    logic [PW-1:0] fall_reg, fall_next;
    logic [PW-1:0] last_reg, last_next;
    logic [PW-1:0] known_reg, known_next;

    logic [PW-1:0] wd;
    logic [PW-1:0] lvl;
    logic [PW-1:0] hiz;
    logic [PW-1:0] pulled;
    logic [PW-1:0] valid_pins;
    logic [PW-1:0] changed;
    logic [PW-1:0] hit;
    logic [PW-1:0] rd;
    logic          irq;

    assign wd  = item.wdata[PW-1:0];
    assign lvl = item.pin_level[PW-1:0];
    assign hiz = item.pin_hiz[PW-1:0];

    // Driven levels, with pull values standing in for floating pins.
    assign pulled = (lvl & ~hiz) | (hiz & pe_reg & pu_reg);

    // Edge detection against the last known input level.
    assign valid_pins = (~hiz | pe_reg) & dir_reg;
    assign changed    = valid_pins & (~known_reg | (pulled ^ last_reg));
    assign hit        = changed & ((pulled & rise_reg) | (~pulled & fall_reg));

    // Read data mux.
    always_comb
    begin
        rd = '0;
        if (item.cmd == CMD_READ)
        begin
            case (item.reg_index)
                REG_DIR:      rd = dir_reg;
                REG_INTR_EN:  rd = ie_reg;
                REG_PULL_EN:  rd = pe_reg;
                REG_PULL_UP:  rd = pu_reg;
                REG_DATA_IN:  rd = pulled;
                REG_DATA_OUT: rd = dout_reg;
                REG_SET:      rd = set_reg;
                REG_CLEAR:    rd = clr_reg;
                REG_INVERT:   rd = inv_reg;
                REG_CHANGE:   rd = chg_reg;
                REG_ACK:      rd = ack_reg;
                REG_RISE_EN:  rd = rise_reg;
                REG_FALL_EN:  rd = fall_reg;
                default:      rd = '0;
            endcase
        end
    end

    // Next state for bus writes and pin samples.
    always_comb
    begin
        dir_next   = dir_reg;
        ie_next    = ie_reg;
        pe_next    = pe_reg;
        pu_next    = pu_reg;
        dout_next  = dout_reg;
        set_next   = set_reg;
        clr_next   = clr_reg;
        inv_next   = inv_reg;
        chg_next   = chg_reg;
        ack_next   = ack_reg;
        rise_next  = rise_reg;
        fall_next  = fall_reg;
        last_next  = last_reg;
        known_next = known_reg;
        irq        = 1'b0;
        case (item.cmd)
            CMD_WRITE:
            begin
                case (item.reg_index)
                    REG_DIR:      dir_next  = wd;
                    REG_INTR_EN:  ie_next   = wd;
                    REG_PULL_EN:  pe_next   = wd;
                    REG_PULL_UP:  pu_next   = wd;
                    REG_DATA_OUT: dout_next = wd;
                    REG_SET:
                    begin
                        set_next  = wd;
                        dout_next = dout_reg | wd;
                    end
                    REG_CLEAR:
                    begin
                        clr_next  = wd;
                        dout_next = dout_reg & ~wd;
                    end
                    REG_INVERT:
                    begin
                        inv_next  = wd;
                        dout_next = dout_reg ^ wd;
                    end
                    REG_CHANGE:   chg_next  = chg_reg & wd;
                    REG_ACK:
                    begin
                        ack_next = wd;
                        chg_next = chg_reg & ~wd;
                    end
                    REG_RISE_EN:  rise_next = wd;
                    REG_FALL_EN:  fall_next = wd;
                    default:      ;
                endcase
            end
            CMD_SAMPLE:
            begin
                chg_next   = chg_reg | hit;
                last_next  = (last_reg & ~valid_pins) | (pulled & valid_pins);
                known_next = (known_reg & ~dir_reg) | valid_pins;
                irq        = |(hit & ie_reg);
            end
            default: ;
        endcase
    end

    // State registers, updated as each request passes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= '0;
            ie_reg    <= '0;
            pe_reg    <= '0;
            pu_reg    <= '0;
            dout_reg  <= '0;
            set_reg   <= '0;
            clr_reg   <= '0;
            inv_reg   <= '0;
            chg_reg   <= '0;
            ack_reg   <= '0;
            rise_reg  <= '0;
            fall_reg  <= '0;
            last_reg  <= '0;
            known_reg <= '0;
        end
        else if (fire)
        begin
            dir_reg   <= dir_next;
            ie_reg    <= ie_next;
            pe_reg    <= pe_next;
            pu_reg    <= pu_next;
            dout_reg  <= dout_next;
            set_reg   <= set_next;
            clr_reg   <= clr_next;
            inv_reg   <= inv_next;
            chg_reg   <= chg_next;
            ack_reg   <= ack_next;
            rise_reg  <= rise_next;
            fall_reg  <= fall_next;
            last_reg  <= last_next;
            known_reg <= known_next;
        end
    end

    // Result reflects the state after this request.
    assign result.rdata   = WORD_W'(rd);
    assign result.pin_out = WORD_W'(dout_next & ~dir_next);
    assign result.pin_oe  = WORD_W'(~dir_next);
    assign result.irq     = irq;

endmodule

`default_nettype wire

>>> hw/rtl/gpio_out_reg.sv
// ----------------------------------------------------------------------------
// gpio_out_reg
// Result register: holds one finished result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_out_reg
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              res_valid,
    output logic                   res_ready,
    input  wire gpio_pkg::result_t res,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output gpio_pkg::result_t      out_res
);
    import gpio_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // A new result may enter when empty or when the held one is taken.
    assign res_ready  = !valid_reg || out_ready;
    assign valid_next = (res_valid && res_ready) || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

>>> hw/rtl/gpio_register_block_core.sv
// ----------------------------------------------------------------------------
// gpio_register_block_core
// GPIO register file with pull handling and edge-detect interrupt.
// ----------------------------------------------------------------------------
// Each request (bus read, bus write or pin sample) passes an input register,
// one pass of bitwise mask logic that also updates the pin registers, and a
// result register, so one request is taken every clock while the master
// stream takes results. A result is loaded into the result register when
// its request leaves the input register, and is then offered on the master
// stream. Every request gives exactly one result carrying the read
// data, the pin drive values and enables after the request, and the
// interrupt flag of a sample. The two registers let the block take one more
// request while a result waits; after that the input stalls until the
// result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_register_block_core
#(
    parameter int PIN_COUNT = gpio_pkg::PIN_COUNT_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // s_tdata: cmd[1:0], reg_index[5:2], wdata[37:6], pin_level[69:38],
    // pin_hiz[101:70], zero padding[103:102]
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [gpio_pkg::IN_TDATA_W-1:0]    s_tdata,
    // m_tdata: rdata[31:0], pin_out[63:32], pin_oe[95:64], irq[96],
    // zero padding[103:97]
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [gpio_pkg::OUT_TDATA_W-1:0]        m_tdata
);
    import gpio_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    res_ready;
    logic    fire;
    result_t res;
    result_t out_res;

    assign in_item = s_tdata[IN_BITS-1:0];

    gpio_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (fire),
        .item       (item)
    );

    // A request is processed when the result register can take its result.
    assign fire = item_valid && res_ready;

    gpio_regfile #(
        .PIN_COUNT (PIN_COUNT)
    ) u_regfile
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (res)
    );

    gpio_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (item_valid),
        .res_ready (res_ready),
        .res       (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = OUT_TDATA_W'(out_res);

endmodule

`default_nettype wire
